FILE: hdl/kda_pkg.sv
// ----------------------------------------------------------------------------
// kda_pkg: shared definitions for the keypad debounce and auto-repeat core
// Holds the key count, counter and code types, and the event kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package kda_pkg;

  localparam int NUM_KEYS = 5;
  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int LEVEL_W = 5;
  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int INDEX_W = 3;
  localparam int KIND_W = 2;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [KEY_W-1:0] key_sel_t;

  typedef enum logic [1:0] {
    KS_OFF = 2'd0,
    KS_ON = 2'd1,
    KS_REPEAT = 2'd2
  } key_state_t;

  typedef enum logic [KIND_W-1:0] {
    EV_BREAK = 2'd0,
    EV_MAKE = 2'd1,
    EV_TIMEOUT = 2'd2
  } event_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_FIRST_REPEAT = 2'd1,
    REG_REPEAT = 2'd2,
    REG_IDLE_LIMIT = 2'd3
  } cfg_reg_t;

  localparam cnt_t DEBOUNCE_RESET = 16'd3;
  localparam cnt_t FIRST_REPEAT_RESET = 16'd50;
  localparam cnt_t REPEAT_RESET = 16'd10;
  localparam cnt_t IDLE_LIMIT_RESET = 16'd600;

endpackage

`default_nettype wire

FILE: hdl/kda_if.sv
// ----------------------------------------------------------------------------
// kda_if: item channels of the keypad debounce and auto-repeat core
// One channel carries scan ticks in, the other carries key events out.
// ----------------------------------------------------------------------------
`default_nettype none

interface kda_key_if;
  logic valid;
  logic ready;
  logic [4:0] key_levels;

  modport source (output valid, output key_levels, input ready);
  modport sink (input valid, input key_levels, output ready);
endinterface

interface kda_event_if;
  logic valid;
  logic ready;
  logic [2:0] key_index;
  logic [1:0] event_kind;
  logic flush_queue;
  logic last;

  modport source (output valid, output key_index, output event_kind,
                  output flush_queue, output last, input ready);
  modport sink (input valid, input key_index, input event_kind,
                input flush_queue, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/keypad_debounce_autorepeat_core.sv
// ----------------------------------------------------------------------------
// keypad_debounce_autorepeat_core: key debounce, typematic repeat and timeout
// Each scan tick item carries the pressed levels of the keys. The core
// visits the keys one per cycle, unless held by a stalled events channel,
// via a shared counter unit and then advances the idle counter.
//
// The core produces break, make and timeout events. The keys channel
// takes one scan tick item while the core is idle. The item is accepted in
// S_IDLE, each key is visited in S_KEY, then S_TIMER advances the idle
// counter and S_DRAIN hands over the final event. Events leave in key
// order, the timeout last, and the last event of a tick carries the last
// flag. One event is held back in a pending register so that the last flag
// is known. It moves to the output register when the next event of the
// tick is found or at the end of the tick. When the receiver stalls, the
// sequencer waits until the output register is free. Configuration writes
// are taken at any edge with the write enable high and must only occur
// while idle. Synchronous reset returns all keys to off, clears the
// counters and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_debounce_autorepeat_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [kda_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kda_pkg::CNT_W-1:0]   cfg_data,
  kda_key_if.sink                     keys,
  kda_event_if.source                 events
);
  import kda_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_KEY = 4'b0010,
    S_TIMER = 4'b0100,
    S_DRAIN = 4'b1000
  } seq_state_t;

  typedef struct packed {
    logic [INDEX_W-1:0] key_index;
    event_kind_t        kind;
    logic               flush;
  } event_t;

  seq_state_t state;
  cnt_t debounce_ticks;
  cnt_t first_repeat_ticks;
  cnt_t repeat_ticks;
  cnt_t idle_limit_ticks;
  key_state_t key_state [NUM_KEYS];
  cnt_t key_counter [NUM_KEYS];
  cnt_t idle_counter;
  logic [LEVEL_W-1:0] levels;
  key_sel_t key_sel;
  logic hit_any;
  logic pend_valid;
  event_t pend;
  logic out_valid;
  event_t out_ev;
  logic out_last;

  key_state_t cur_st;
  cnt_t cur_cnt;
  logic pressed;
  cnt_t unit_count;
  cnt_t unit_limit;
  cnt_t unit_inc;
  logic unit_reached;
  logic key_ev;
  event_t key_event;
  key_state_t st_next;
  cnt_t cnt_next;
  logic out_free;
  logic out_load;

  kda_tick_unit u_tick (
    .count     (unit_count),
    .limit     (unit_limit),
    .count_inc (unit_inc),
    .reached   (unit_reached)
  );

  assign out_free = !out_valid || events.ready;
  assign keys.ready = (state == S_IDLE);
  assign out_load = pend_valid && out_free &&
                    (((state == S_KEY) && key_ev) ||
                     ((state == S_TIMER) && unit_reached) ||
                     (state == S_DRAIN));

  always_comb begin
    cur_st = key_state[key_sel];
    cur_cnt = key_counter[key_sel];
    pressed = levels[key_sel];
    if (state == S_TIMER) begin
      unit_count = hit_any ? '0 : idle_counter;
      unit_limit = idle_limit_ticks;
    end else begin
      unit_count = cur_cnt;
      case (cur_st)
        KS_OFF: unit_limit = debounce_ticks;
        KS_ON: unit_limit = first_repeat_ticks;
        default: unit_limit = repeat_ticks;
      endcase
    end
    key_ev = 1'b0;
    key_event.key_index = INDEX_W'(key_sel);
    key_event.kind = EV_MAKE;
    key_event.flush = 1'b0;
    st_next = cur_st;
    cnt_next = cur_cnt;
    if (cur_st != KS_OFF && !pressed) begin
      key_ev = 1'b1;
      key_event.kind = EV_BREAK;
      key_event.flush = 1'b1;
      st_next = KS_OFF;
      cnt_next = '0;
    end else if (pressed) begin
      cnt_next = unit_inc;
      if (unit_reached) begin
        key_ev = 1'b1;
        cnt_next = '0;
        case (cur_st)
          KS_OFF: st_next = KS_ON;
          KS_ON: st_next = KS_REPEAT;
          default: st_next = cur_st;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      first_repeat_ticks <= FIRST_REPEAT_RESET;
      repeat_ticks <= REPEAT_RESET;
      idle_limit_ticks <= IDLE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE: debounce_ticks <= cfg_data;
        REG_FIRST_REPEAT: first_repeat_ticks <= cfg_data;
        REG_REPEAT: repeat_ticks <= cfg_data;
        REG_IDLE_LIMIT: idle_limit_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_state[i] <= KS_OFF;
        key_counter[i] <= '0;
      end
      idle_counter <= '0;
      key_sel <= '0;
      hit_any <= 1'b0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (keys.valid) begin
            levels <= keys.key_levels;
            key_sel <= '0;
            hit_any <= 1'b0;
            state <= S_KEY;
          end
        end
        S_KEY: begin
          if (!(key_ev && pend_valid && !out_free)) begin
            key_state[key_sel] <= st_next;
            key_counter[key_sel] <= cnt_next;
            if (key_ev) begin
              if (pend_valid) begin
                out_ev <= pend;
                out_last <= 1'b0;
              end
              pend <= key_event;
              pend_valid <= 1'b1;
              hit_any <= 1'b1;
            end
            if (key_sel == key_sel_t'(NUM_KEYS - 1)) begin
              state <= S_TIMER;
            end else begin
              key_sel <= key_sel + key_sel_t'(1);
            end
          end
        end
        S_TIMER: begin
          if (unit_reached) begin
            if (!(pend_valid && !out_free)) begin
              if (pend_valid) begin
                out_ev <= pend;
                out_last <= 1'b0;
              end
              pend.key_index <= '0;
              pend.kind <= EV_TIMEOUT;
              pend.flush <= 1'b0;
              pend_valid <= 1'b1;
              idle_counter <= '0;
              state <= S_DRAIN;
            end
          end else begin
            idle_counter <= unit_inc;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_ev <= pend;
            out_last <= 1'b1;
            pend_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign events.valid = out_valid;
  assign events.key_index = out_ev.key_index;
  assign events.event_kind = out_ev.kind;
  assign events.flush_queue = out_ev.flush;
  assign events.last = out_last;

endmodule

`default_nettype wire

FILE: hdl/kda_tick_unit.sv
// ----------------------------------------------------------------------------
// kda_tick_unit: shared saturating tick counter step and threshold compare
// Used once per key and once for the idle counter on every scan tick.
// ----------------------------------------------------------------------------
`default_nettype none

module kda_tick_unit (
  input  kda_pkg::cnt_t count,
  input  kda_pkg::cnt_t limit,
  output kda_pkg::cnt_t count_inc,
  output logic          reached
);
  import kda_pkg::*;

  assign count_inc = (count == {CNT_W{1'b1}}) ? count : count + cnt_t'(1);
  assign reached = (count_inc >= limit);

endmodule

`default_nettype wire
